@@ src/gost_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gost_pkg;

    localparam int ROUND_COUNT = 32;
    localparam int KEY_WORDS   = 8;
    localparam int ROT_BITS    = 11;
    localparam int WORD_W      = 32;
    localparam int KEY_IDX_W   = $clog2(KEY_WORDS);
    localparam int ROUND_IDX_W = $clog2(ROUND_COUNT);

    localparam logic ACT_ENCRYPT = 1'b0;
    localparam logic ACT_DECRYPT = 1'b1;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic valid;
        logic action;
    } t_ctl;

    // Test-parameter S-box set, row 0 serves the top nibble.
    localparam logic [3:0] SBOX [8][16] = '{
        '{4'h4, 4'hA, 4'h9, 4'h2, 4'hD, 4'h8, 4'h0, 4'hE,
          4'h6, 4'hB, 4'h1, 4'hC, 4'h7, 4'hF, 4'h5, 4'h3},
        '{4'hE, 4'hB, 4'h4, 4'hC, 4'h6, 4'hD, 4'hF, 4'hA,
          4'h2, 4'h3, 4'h8, 4'h1, 4'h0, 4'h7, 4'h5, 4'h9},
        '{4'h5, 4'h8, 4'h1, 4'hD, 4'hA, 4'h3, 4'h4, 4'h2,
          4'hE, 4'hF, 4'hC, 4'h7, 4'h6, 4'h0, 4'h9, 4'hB},
        '{4'h7, 4'hD, 4'hA, 4'h1, 4'h0, 4'h8, 4'h9, 4'hF,
          4'hE, 4'h4, 4'h6, 4'hC, 4'hB, 4'h2, 4'h5, 4'h3},
        '{4'h6, 4'hC, 4'h7, 4'h1, 4'h5, 4'hF, 4'hD, 4'h8,
          4'h4, 4'hA, 4'h9, 4'hE, 4'h0, 4'h3, 4'hB, 4'h2},
        '{4'h4, 4'hB, 4'hA, 4'h0, 4'h7, 4'h2, 4'h1, 4'hD,
          4'h3, 4'h6, 4'h8, 4'h5, 4'h9, 4'hC, 4'hF, 4'hE},
        '{4'hD, 4'hB, 4'h4, 4'h1, 4'h3, 4'hF, 4'h5, 4'h9,
          4'h0, 4'hA, 4'hE, 4'h7, 4'h6, 4'h8, 4'h2, 4'hC},
        '{4'h1, 4'hF, 4'hD, 4'h0, 4'h5, 4'h7, 4'hA, 4'h4,
          4'h9, 4'h2, 4'h3, 4'hE, 4'h6, 4'hB, 4'h8, 4'hC}
    };

    // Key add, S-box layer, rotate left.
    function automatic t_word round_fn(input t_word half, input t_word key);
        t_word x;
        t_word y;
        x = half + key;
        for (int n = 0; n < 8; n++) begin
            y[WORD_W-1-4*n -: 4] = SBOX[n][x[WORD_W-1-4*n -: 4]];
        end
        return {y[WORD_W-1-ROT_BITS:0], y[WORD_W-1:WORD_W-ROT_BITS]};
    endfunction

    // Forward order for all but the last eight rounds, then reversed (encrypt),
    // or forward for the first eight rounds and reversed for the rest (decrypt).
    function automatic logic [KEY_IDX_W-1:0] key_index(
        input logic [ROUND_IDX_W-1:0] rnd,
        input logic                   dec
    );
        logic [KEY_IDX_W-1:0] pos;
        logic                 fwd;
        pos = rnd[KEY_IDX_W-1:0];
        if (dec == ACT_DECRYPT) begin
            fwd = (rnd < ROUND_IDX_W'(KEY_WORDS));
        end else begin
            fwd = (rnd < ROUND_IDX_W'(ROUND_COUNT - KEY_WORDS));
        end
        return fwd ? pos : ~pos;
    endfunction

endpackage

`default_nettype wire

@@ src/gost_round_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gost_round_cell
    import gost_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_ctl  i_ctl,
    input  wire t_word i_left,
    input  wire t_word i_right,
    input  wire t_word i_key_enc,
    input  wire t_word i_key_dec,
    output t_ctl       o_ctl,
    output t_word      o_left,
    output t_word      o_right
);

    t_ctl  r_ctl;
    t_word r_left;
    t_word r_right;
    t_word n_left;
    t_word n_right;
    t_word key;

    always_comb begin
        key     = (i_ctl.action == ACT_DECRYPT) ? i_key_dec : i_key_enc;
        n_left  = i_right;
        n_right = i_left ^ round_fn(i_right, key);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    // payload needs no reset: valid travels alongside
    always_ff @(posedge i_clk) begin
        r_left  <= n_left;
        r_right <= n_right;
    end

    assign o_ctl   = r_ctl;
    assign o_left  = r_left;
    assign o_right = r_right;

endmodule

`default_nettype wire

@@ src/gost_feistel_block_cipher_top.sv @@
// Datapath: a chain of 32 round cells, one Feistel round per cell, each
// cell registering its word before passing it on.
// Throughput: one word per cycle; busy is never raised, and the receiver
// cannot stall, so o_valid strobes for exactly one cycle per word.
// Reset (synchronous, active low) drops all words in flight and clears
// the key words to zero.
`timescale 1ns / 1ps
`default_nettype none

module gost_feistel_block_cipher_top
    import gost_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 i_action,
    input  wire t_word                i_block_left,
    input  wire t_word                i_block_right,
    output logic                      o_valid,
    output t_word                     o_out_left,
    output t_word                     o_out_right,
    input  wire logic                 i_cfg_we,
    input  wire logic [KEY_IDX_W-1:0] i_cfg_index,
    input  wire t_word                i_cfg_data
);

    t_word r_key [KEY_WORDS];

    t_ctl  ctl   [ROUND_COUNT+1];
    t_word left  [ROUND_COUNT+1];
    t_word right [ROUND_COUNT+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KEY_WORDS; k++) begin
                r_key[k] <= '0;
            end
        end else if (i_cfg_we) begin
            r_key[i_cfg_index] <= i_cfg_data;
        end
    end

    assign busy = 1'b0;

    assign ctl[0]   = t_ctl'{start, i_action};
    assign left[0]  = i_block_left;
    assign right[0] = i_block_right;

    for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
        gost_round_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (ctl[g]),
            .i_left    (left[g]),
            .i_right   (right[g]),
            .i_key_enc (r_key[key_index(ROUND_IDX_W'(g), ACT_ENCRYPT)]),
            .i_key_dec (r_key[key_index(ROUND_IDX_W'(g), ACT_DECRYPT)]),
            .o_ctl     (ctl[g+1]),
            .o_left    (left[g+1]),
            .o_right   (right[g+1])
        );
    end

    // undo the swap of the last round
    assign o_valid     = ctl[ROUND_COUNT].valid;
    assign o_out_left  = right[ROUND_COUNT];
    assign o_out_right = left[ROUND_COUNT];

endmodule

`default_nettype wire

@@ tb/gost_block_checker.sv @@
`timescale 1ns / 1ps

module gost_block_checker
    import gost_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic                 i_busy,
    input  wire logic                 i_action,
    input  wire t_word                i_block_left,
    input  wire t_word                i_block_right,
    input  wire logic                 i_valid,
    input  wire t_word                i_out_left,
    input  wire t_word                i_out_right,
    input  wire logic                 i_cfg_we,
    input  wire logic [KEY_IDX_W-1:0] i_cfg_index,
    input  wire t_word                i_cfg_data,
    output int                        o_mismatches,
    output int                        o_pending
);

    typedef struct packed {
        t_word left;
        t_word right;
    } t_block;

    // One row per nibble position, entry j in nibble j from the top.
    localparam logic [63:0] SUBST_ROWS [8] = '{
        64'h4A92_D80E_6B1C_7F53,
        64'hEB4C_6DFA_2381_0759,
        64'h581D_A342_EFC7_609B,
        64'h7DA1_089F_E46C_B253,
        64'h6C71_5FD8_4A9E_03B2,
        64'h4BA0_721D_3685_9CFE,
        64'hDB41_3F59_0AE7_682C,
        64'h1FD0_57A4_923E_6B8C
    };

    t_word  key_copy [KEY_WORDS];
    t_block expected_blocks [$];
    int     mismatch_count = 0;

    function automatic t_word round_mix(input t_word half, input t_word key);
        t_word sum;
        t_word sub;
        int    nib;
        sum = half + key;
        for (int n = 0; n < 8; n++) begin
            nib = sum[28-4*n +: 4];
            sub[28-4*n +: 4] = SUBST_ROWS[n][63-4*nib -: 4];
        end
        return {sub[WORD_W-1-ROT_BITS:0], sub[WORD_W-1:WORD_W-ROT_BITS]};
    endfunction

    function automatic t_block encipher_block(input logic act, input t_word left_in,
                                              input t_word right_in);
        t_word left;
        t_word right;
        t_word held;
        int    pos;
        int    forward_rounds;
        left  = left_in;
        right = right_in;
        // Decrypt walks the key forward only once, encrypt three times.
        forward_rounds = (act == ACT_DECRYPT) ? KEY_WORDS : ROUND_COUNT - KEY_WORDS;
        for (int r = 0; r < ROUND_COUNT; r++) begin
            pos = r % KEY_WORDS;
            if (r >= forward_rounds) begin
                pos = KEY_WORDS - 1 - pos;
            end
            held  = right;
            right = left ^ round_mix(right, key_copy[pos]);
            left  = held;
        end
        // No swap after the last round.
        return t_block'{right, left};
    endfunction

    always @(posedge i_clk) begin
        t_block want;
        if (!i_rst_n) begin
            foreach (key_copy[k]) key_copy[k] = '0;
            expected_blocks.delete();
        end else begin
            if (i_valid) begin
                if (expected_blocks.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: unexpected word left %h right %h",
                                 $realtime, i_out_left, i_out_right);
                    end
                end else begin
                    want = expected_blocks.pop_front();
                    if (want.left !== i_out_left || want.right !== i_out_right) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("%0t: word differs, expected %h %h, got %h %h",
                                     $realtime, want.left, want.right,
                                     i_out_left, i_out_right);
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                key_copy[i_cfg_index] = i_cfg_data;
            end
            if (i_start && !i_busy) begin
                expected_blocks.push_back(encipher_block(i_action, i_block_left,
                                                         i_block_right));
            end
        end
        o_pending    <= expected_blocks.size();
        o_mismatches <= mismatch_count;
    end

endmodule

@@ tb/gost_feistel_block_cipher_top_test.sv @@
`timescale 1ns / 1ps

module gost_feistel_block_cipher_top_test;
    import gost_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 action;
    t_word                block_left;
    t_word                block_right;
    logic                 valid;
    t_word                out_left;
    t_word                out_right;
    logic                 cfg_we;
    logic [KEY_IDX_W-1:0] cfg_index;
    t_word                cfg_data;

    t_word key_set [KEY_WORDS];
    int    mismatches;
    int    pending;
    int    idle_pct;

    gost_feistel_block_cipher_top DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (action),
        .i_block_left  (block_left),
        .i_block_right (block_right),
        .o_valid       (valid),
        .o_out_left    (out_left),
        .o_out_right   (out_right),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    gost_block_checker checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_action      (action),
        .i_block_left  (block_left),
        .i_block_right (block_right),
        .i_valid       (valid),
        .i_out_left    (out_left),
        .i_out_right   (out_right),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #5ms;
        $display("gost_feistel_block_cipher_top: mismatch");
        $finish;
    end

    // Offer one word, hold it until taken, then maybe idle for a while.
    task automatic send_block(input logic act, input t_word left, input t_word right);
        int gap;
        start       <= 1'b1;
        action      <= act;
        block_left  <= left;
        block_right <= right;
        @(posedge clk);
        while (busy) @(posedge clk);
        if ($urandom_range(99) < idle_pct) begin
            gap = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(4, 1);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic load_key_set();
        for (int k = 0; k < KEY_WORDS; k++) begin
            cfg_we    <= 1'b1;
            cfg_index <= KEY_IDX_W'(k);
            cfg_data  <= key_set[k];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Lean on the all-zero and all-one halves now and then.
    function automatic t_word pick_half();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    initial begin
        rst_n       = 1'b0;
        start       = 1'b0;
        action      = ACT_ENCRYPT;
        block_left  = '0;
        block_right = '0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        idle_pct    = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Keys still zero from reset.
        send_block(ACT_ENCRYPT, '0, '0);
        send_block(ACT_DECRYPT, '0, '0);
        send_block(ACT_ENCRYPT, '1, '1);
        send_block(ACT_DECRYPT, '1, '1);
        start <= 1'b0;
        drain();

        // All-ones key: every key add wraps unless the half is zero.
        foreach (key_set[k]) key_set[k] = '1;
        load_key_set();
        send_block(ACT_ENCRYPT, '0, '0);
        send_block(ACT_DECRYPT, '0, '0);
        send_block(ACT_ENCRYPT, '1, '1);
        send_block(ACT_DECRYPT, '1, '1);
        send_block(ACT_ENCRYPT, '0, '1);
        send_block(ACT_DECRYPT, '1, '0);
        start <= 1'b0;
        drain();

        // Distinct words expose any slip in the key order.
        foreach (key_set[k]) key_set[k] = 32'hFEDC_BA98 ^ (32'h1111_1111 * k);
        load_key_set();
        send_block(ACT_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
        send_block(ACT_DECRYPT, 32'h8000_0000, 32'h0000_0001);
        send_block(ACT_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF);
        send_block(ACT_DECRYPT, 32'h0123_4567, 32'h89AB_CDEF);
        send_block(ACT_ENCRYPT, 32'hFFFF_FFFE, 32'h7FFF_FFFF);
        send_block(ACT_DECRYPT, 32'hFFFF_FFFE, 32'h7FFF_FFFF);
        start <= 1'b0;
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                1: begin
                    foreach (key_set[k]) key_set[k] = '1;
                    idle_pct = 67;
                end
                3: begin
                    foreach (key_set[k]) key_set[k] = k[0] ? 32'hAAAA_AAAA : 32'h5555_5555;
                    idle_pct = 27;
                end
                4: begin
                    foreach (key_set[k]) key_set[k] = $urandom();
                    idle_pct = 67;
                end
                5: begin
                    foreach (key_set[k]) key_set[k] = '0;
                    idle_pct = 27;
                end
                default: begin
                    foreach (key_set[k]) key_set[k] = $urandom();
                    idle_pct = 0;
                end
            endcase
            load_key_set();
            repeat (275) begin
                send_block(logic'($urandom_range(1)), pick_half(), pick_half());
            end
            start <= 1'b0;
            drain();
        end

        repeat (40) @(posedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("gost_feistel_block_cipher_top: match");
        end else begin
            $display("gost_feistel_block_cipher_top: mismatch");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/gost_pkg.sv
src/gost_round_cell.sv
src/gost_feistel_block_cipher_top.sv
tb/gost_block_checker.sv
tb/gost_feistel_block_cipher_top_test.sv
